// ===== hw/rtl/mm4_pkg.sv =====
// Shared constants, types and command format for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

    // Matrix geometry and element format
    localparam int DIM        = 4;
    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Fixed channel field widths
    localparam int IN_COLS     = 4;
    localparam int FIELD_W     = 32;
    localparam int ROW_IDX_W   = 2;
    localparam int OUT_ROW_W   = 2;

    // Derived widths
    localparam int ROW_W    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int PROD_W   = 2 * ELEM_WIDTH;
    localparam int ACC_W    = PROD_W + ROW_W;
    localparam int OUT_ROWS = (DIM < IN_COLS) ? DIM : IN_COLS;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [DIM-1:0][ELEM_WIDTH-1:0] row_t;

    typedef struct packed {
        logic             store;    // write data into the selected matrix row
        logic             sel;      // 0 = A, 1 = B
        logic [ROW_W-1:0] row;
        row_t             data;
        logic             compute;  // run the product after the store
    } cmd_t;

endpackage

// ===== hw/rtl/mm4_if.sv =====
// Input and result channel interfaces of the matrix multiplier.
interface mm4_in_if;
    import mm4_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        operand_select;
    logic [ROW_IDX_W-1:0]        row_index;
    logic signed [FIELD_W-1:0]   elem0;
    logic signed [FIELD_W-1:0]   elem1;
    logic signed [FIELD_W-1:0]   elem2;
    logic signed [FIELD_W-1:0]   elem3;
    logic                        compute;

    modport source (
        output valid, operand_select, row_index, elem0, elem1, elem2, elem3, compute,
        input  ready
    );
    modport sink (
        input  valid, operand_select, row_index, elem0, elem1, elem2, elem3, compute,
        output ready
    );
endinterface

interface mm4_out_if;
    import mm4_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [OUT_ROW_W-1:0]        out_row;
    logic signed [FIELD_W-1:0]   prod0;
    logic signed [FIELD_W-1:0]   prod1;
    logic signed [FIELD_W-1:0]   prod2;
    logic signed [FIELD_W-1:0]   prod3;
    logic                        saturated;
    logic                        last_row;

    modport source (
        output valid, out_row, prod0, prod1, prod2, prod3, saturated, last_row,
        input  ready
    );
    modport sink (
        input  valid, out_row, prod0, prod1, prod2, prod3, saturated, last_row,
        output ready
    );
endinterface

// ===== hw/rtl/mm4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/mm4_front.sv =====
// Front end: accepts input items and turns them into store/compute commands.
module mm4_front (
    mm4_in_if.sink         req,
    output logic           push_valid,
    input  logic           push_ready,
    output mm4_pkg::cmd_t  push_data
);
    import mm4_pkg::*;

    logic [FIELD_W-1:0] elems [IN_COLS];
    row_t               row_data;
    logic               do_store;

    assign elems[0] = req.elem0;
    assign elems[1] = req.elem1;
    assign elems[2] = req.elem2;
    assign elems[3] = req.elem3;

    // Columns past the fourth load as zero; extra input columns are dropped.
    for (genvar j = 0; j < DIM; j++)
    begin : g_col
        if (j < IN_COLS)
        begin : g_in
            assign row_data[j] = elems[j][ELEM_WIDTH-1:0];
        end
        else
        begin : g_zero
            assign row_data[j] = '0;
        end
    end

    // Rows beyond the matrix are not stored, but a compute request still runs.
    assign do_store = int'(req.row_index) < DIM;

    always_comb
    begin
        push_data.store   = do_store;
        push_data.sel     = req.operand_select;
        push_data.row     = ROW_W'(req.row_index);
        push_data.data    = row_data;
        push_data.compute = req.compute;
    end

    // Items with nothing to do are taken and dropped.
    assign push_valid = req.valid && (do_store || req.compute);
    assign req.ready  = push_ready;
endmodule

// ===== hw/rtl/mm4_queue.sv =====
// Short command FIFO between the front end and the execution back end.
module mm4_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mm4_pkg::cmd_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mm4_pkg::cmd_t  pop_data
);
    import mm4_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== hw/rtl/mm4_back.sv =====
// Back end: executes row stores and runs the multiply-accumulate sequencer.
module mm4_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  mm4_pkg::cmd_t  pop_data,
    mm4_out_if.source      res
);
    import mm4_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [ROW_W-1:0] i_reg;
    logic [ROW_W-1:0] i_next;
    logic [ROW_W-1:0] k_reg;
    logic [ROW_W-1:0] k_next;
    logic             last_k;
    logic             last_i;

    // Matrix storage
    logic             a_we;
    logic             b_we;
    row_t             a_rdata;
    row_t             b_rdata;

    // MAC pipeline
    logic             s1_v_reg;
    logic             s1_v_next;
    logic [ROW_W-1:0] s1_k_reg;
    logic             s1_last_reg;
    logic             s2_v_reg;
    logic             s2_first_reg;
    logic             s2_last_reg;
    logic signed [ELEM_WIDTH-1:0] a_elem;
    logic signed [ELEM_WIDTH-1:0] b_elem  [DIM];
    logic signed [PROD_W-1:0]     prod_reg [DIM];
    logic signed [ACC_W-1:0]      acc_reg  [DIM];
    logic                         acc_ready_reg;

    // Rounding and saturation
    logic signed [ACC_W-1:0]  shifted [DIM];
    logic [ELEM_WIDTH-1:0]    sat_val [DIM];
    logic [DIM-1:0]           sat_flag;

    // Output register
    logic                     out_load;
    logic                     out_valid_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic [ELEM_WIDTH-1:0]    out_val_reg [DIM];
    logic                     out_sat_reg;
    logic                     out_last_reg;
    logic [FIELD_W-1:0]       prod_field [IN_COLS];

    mm4_ram #(.WIDTH(DIM * ELEM_WIDTH), .DEPTH(DIM)) u_mat_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (pop_data.row),
        .wdata (pop_data.data),
        .raddr (i_reg),
        .rdata (a_rdata)
    );

    mm4_ram #(.WIDTH(DIM * ELEM_WIDTH), .DEPTH(DIM)) u_mat_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (pop_data.row),
        .wdata (pop_data.data),
        .raddr (k_reg),
        .rdata (b_rdata)
    );

    assign last_k = k_reg == ROW_W'(DIM - 1);
    assign last_i = i_reg == ROW_W'(OUT_ROWS - 1);

    // Sequencer: one row of A against all of B, k stepping once per cycle.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        pop_ready  = 1'b0;
        a_we       = 1'b0;
        b_we       = 1'b0;
        s1_v_next  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    a_we = pop_data.store && !pop_data.sel;
                    b_we = pop_data.store && pop_data.sel;
                    if (pop_data.compute)
                    begin
                        state_next = S_ISSUE;
                        i_next     = '0;
                        k_next     = '0;
                    end
                end
            end
            S_ISSUE:
            begin
                s1_v_next = 1'b1;
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = S_WAIT;
                end
                else
                begin
                    k_next = k_reg + ROW_W'(1);
                end
            end
            S_WAIT:
            begin
                if (acc_ready_reg && (!out_valid_reg || res.ready))
                begin
                    out_load = 1'b1;
                    if (last_i)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + ROW_W'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            acc_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s1_v_reg;
            if (s2_v_reg && s2_last_reg)
            begin
                acc_ready_reg <= 1'b1;
            end
            else if (out_load)
            begin
                acc_ready_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign a_elem = signed'(a_rdata[s1_k_reg]);

    for (genvar j = 0; j < DIM; j++)
    begin : g_lane
        assign b_elem[j] = signed'(b_rdata[j]);

        // Full-width sum, then floor shift and clip to the element range.
        assign shifted[j]  = acc_reg[j] >>> FRAC_BITS;
        assign sat_flag[j] = !((&shifted[j][ACC_W-1:ELEM_WIDTH-1]) ||
                               !(|shifted[j][ACC_W-1:ELEM_WIDTH-1]));
        assign sat_val[j]  = sat_flag[j] ?
                             {shifted[j][ACC_W-1], {(ELEM_WIDTH-1){!shifted[j][ACC_W-1]}}} :
                             shifted[j][ELEM_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        s1_k_reg     <= k_reg;
        s1_last_reg  <= last_k;
        s2_first_reg <= s1_k_reg == '0;
        s2_last_reg  <= s1_last_reg;
        for (int j = 0; j < DIM; j++)
        begin
            prod_reg[j] <= a_elem * b_elem[j];
            if (s2_v_reg)
            begin
                acc_reg[j] <= (s2_first_reg ? '0 : acc_reg[j]) + ACC_W'(prod_reg[j]);
            end
            if (out_load)
            begin
                out_val_reg[j] <= sat_val[j];
            end
        end
        if (out_load)
        begin
            out_row_reg  <= i_reg;
            out_sat_reg  <= |sat_flag;
            out_last_reg <= i_reg == ROW_W'(DIM - 1);
        end
    end

    // Columns past the matrix width read as zero.
    for (genvar j = 0; j < IN_COLS; j++)
    begin : g_field
        if (j < DIM)
        begin : g_used
            assign prod_field[j] = FIELD_W'(signed'(out_val_reg[j]));
        end
        else
        begin : g_unused
            assign prod_field[j] = '0;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_row   = OUT_ROW_W'(out_row_reg);
    assign res.prod0     = prod_field[0];
    assign res.prod1     = prod_field[1];
    assign res.prod2     = prod_field[2];
    assign res.prod3     = prod_field[3];
    assign res.saturated = out_sat_reg;
    assign res.last_row  = out_last_reg;

    // Pipeline must be empty whenever new stores may land in the matrices.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !s1_v_reg && !s2_v_reg)
        else $error("MAC pipeline busy while sequencer idle");

    a_acc_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        acc_ready_reg |-> state_reg == S_WAIT)
        else $error("accumulated row pending outside wait state");

    a_load_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !s1_v_reg && !s2_v_reg)
        else $error("row result taken before accumulation finished");
endmodule

// ===== hw/rtl/matrix_multiply_4x4.sv =====
// Top level of the 4x4 signed Q16.16 matrix multiplier.
// Usage:
//   req : input items. Each item stores one row of four elements into the
//         left (A) or right (B) matrix; with compute set, the product A*B is
//         produced after the row is stored.
//   res : result items, four product rows per compute, row 0 first. Each
//         carries the row index, four saturated Q16.16 columns, a saturation
//         flag and last_row on the final row.
//   Entries are summed exactly, shifted right by 16 (floor), then clipped.
//   Every entry used by a compute must have been written since reset.
// Timing:
//   A 4-entry command queue sits between the front end and the back end,
//   so items are taken while a product is still being computed.
//   Row store: written in the back end as the command is taken. Compute:
//   product rows one after another, each issuing 4 MAC steps through four
//   32x32 multiplier lanes (RAM read, multiply, accumulate), then a
//   saturate/load step; the back end takes no new item until the last row is loaded.
// Reset: clears queue, sequencer and output valid; matrices undefined until written.
// Stall: a held result keeps the sequencer waiting before the next row is
//   loaded; the queue keeps accepting items until it is full.
module matrix_multiply_4x4 (
    input  logic      clk,
    input  logic      rst_n,
    mm4_in_if.sink    req,
    mm4_out_if.source res
);
    import mm4_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    // Classify items into commands
    mm4_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouples intake from execution
    mm4_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Matrix storage, MAC lanes and output register
    mm4_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res       (res)
    );
endmodule
